[sv/qtu_pkg.sv]
// ----------------------------------------------------------------------------
// qtu_pkg: shared constants and types for the q table update block
// Table geometry, fixed-point widths, register indexes and the command
// bundle that the controller sends to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package qtu_pkg;

    // table geometry
    localparam int NUM_STATES  = 256;
    localparam int NUM_ACTIONS = 8;
    localparam int DEPTH       = NUM_STATES * NUM_ACTIONS;
    localparam int ST_W        = $clog2(NUM_STATES);
    localparam int ACT_W       = $clog2(NUM_ACTIONS);
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(NUM_ACTIONS + 1);

    // stream field widths
    localparam int PRIOR_W  = 8;
    localparam int ACTION_W = 3;
    localparam int NEXT_W   = 8;
    localparam int Q_W      = 16;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;

    // configuration registers
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT   = 1'd1;
    localparam logic [CFG_W-1:0] LEARN_RATE_RESET = 16'd6554;
    localparam logic [CFG_W-1:0] DISCOUNT_RESET   = 16'd58982;

    // arithmetic widths
    localparam int DM_W    = CFG_W + Q_W + 1;     // discount * max
    localparam int TGT_W   = DM_W + 1;            // bracketed target in Q18.16
    localparam int LO_W    = 17;                  // low split of target
    localparam int HI_W    = TGT_W - LO_W;        // signed high split
    localparam int PLO_W   = CFG_W + LO_W;
    localparam int PHI_W   = CFG_W + 1 + HI_W;
    localparam int PROD_W  = PHI_W + LO_W;
    localparam int SHIFT   = 32;
    localparam int DELTA_W = PROD_W - SHIFT;
    localparam int SUM_W   = DELTA_W + 1;
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(64'd1 << (SHIFT - 1));
    localparam logic [Q_W-1:0] Q_POS_LIMIT = 16'h7fff;
    localparam logic [Q_W-1:0] Q_NEG_LIMIT = 16'h8000;

    typedef struct packed {
        logic              load;
        logic              rd_en;
        logic              rd_old;
        logic [ACT_W-1:0]  rd_idx;
        logic              max_first;
        logic              max_cmp;
        logic              old_cap;
        logic              mul;
        logic              tgt;
        logic              mlo;
        logic              mhi;
        logic              fin;
        logic              clr;
        logic [ADDR_W-1:0] clr_addr;
    } t_cmd;

endpackage

`default_nettype wire

[sv/qtu_ram.sv]
// ----------------------------------------------------------------------------
// qtu_ram: generic simple dual-port ram
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module qtu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[sv/qtu_ctrl.sv]
// ----------------------------------------------------------------------------
// qtu_ctrl: sequencer for the q table update
// Runs the clearing pass, walks the next-state row, then steps the
// arithmetic and the write-back, and owns the stream handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module qtu_ctrl import qtu_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_s_valid,
    output logic      o_s_ready,
    output logic      o_m_valid,
    input  wire logic i_m_ready,
    output t_cmd      o_cmd
);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_READ  = 4'd2;
    localparam logic [3:0] ST_DRAIN = 4'd3;
    localparam logic [3:0] ST_MUL   = 4'd4;
    localparam logic [3:0] ST_TGT   = 4'd5;
    localparam logic [3:0] ST_MLO   = 4'd6;
    localparam logic [3:0] ST_MHI   = 4'd7;
    localparam logic [3:0] ST_FIN   = 4'd8;

    logic [3:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic              r_ovalid, n_ovalid;
    t_cmd              w_cmd;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_clr    = r_clr;
        n_ovalid = r_ovalid;
        w_cmd    = '0;
        // output register drains independently of the sequence
        if (r_ovalid && i_m_ready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            ST_CLEAR: begin
                w_cmd.clr      = 1'b1;
                w_cmd.clr_addr = r_clr;
                n_clr          = r_clr + 1'b1;
                if (r_clr == ADDR_W'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_s_valid) begin
                    w_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = ST_READ;
                end
            end
            ST_READ: begin
                // read data is registered, so it arrives in the cycle after the address
                w_cmd.rd_en     = 1'b1;
                w_cmd.rd_idx    = r_cnt[ACT_W-1:0];
                w_cmd.rd_old    = (r_cnt == CNT_W'(NUM_ACTIONS));
                w_cmd.max_first = (r_cnt == CNT_W'(1));
                w_cmd.max_cmp   = (r_cnt >= CNT_W'(2));
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_ACTIONS)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                w_cmd.old_cap = 1'b1;
                n_state       = ST_MUL;
            end
            ST_MUL: begin
                w_cmd.mul = 1'b1;
                n_state   = ST_TGT;
            end
            ST_TGT: begin
                w_cmd.tgt = 1'b1;
                n_state   = ST_MLO;
            end
            ST_MLO: begin
                w_cmd.mlo = 1'b1;
                n_state   = ST_MHI;
            end
            ST_MHI: begin
                w_cmd.mhi = 1'b1;
                n_state   = ST_FIN;
            end
            ST_FIN: begin
                // hold until the output register is free
                if (!r_ovalid || i_m_ready) begin
                    w_cmd.fin = 1'b1;
                    n_ovalid  = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_cnt    <= '0;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_s_ready = (r_state == ST_IDLE);
    assign o_m_valid = r_ovalid;
    assign o_cmd     = w_cmd;

endmodule

`default_nettype wire

[sv/qtu_dp.sv]
// ----------------------------------------------------------------------------
// qtu_dp: datapath for the q table update
// Holds the table memory, the settings, the row maximum search and the
// fixed-point update with rounding and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module qtu_dp import qtu_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata,
    input  wire logic [PRIOR_W-1:0]   i_prior_state,
    input  wire logic [ACTION_W-1:0]  i_taken_action,
    input  wire logic [NEXT_W-1:0]    i_next_state,
    input  wire logic [Q_W-1:0]       i_reward_value,
    output logic      [Q_W-1:0]       o_updated_value,
    output logic      [Q_W-1:0]       o_next_row_max,
    output logic                      o_clipped
);

    logic [CFG_W-1:0]         r_lr;
    logic [CFG_W-1:0]         r_disc;
    logic [ST_W-1:0]          r_prior;
    logic [ACT_W-1:0]         r_act;
    logic [ST_W-1:0]          r_nxt;
    logic signed [Q_W-1:0]    r_reward;
    logic signed [Q_W-1:0]    r_best;
    logic signed [Q_W-1:0]    r_old;
    logic signed [DM_W-1:0]   r_dm;
    logic signed [TGT_W-1:0]  r_tgt;
    logic [PLO_W-1:0]         r_plo;
    logic [PROD_W-1:0]        r_prod;
    logic [Q_W-1:0]           r_upd;
    logic [Q_W-1:0]           r_max;
    logic                     r_clip;

    logic [ADDR_W-1:0]        w_base;
    logic [ADDR_W-1:0]        w_slot;
    logic [ADDR_W-1:0]        w_raddr;
    logic [ADDR_W-1:0]        w_waddr;
    logic [Q_W-1:0]           w_wdata;
    logic                     w_we;
    logic signed [Q_W-1:0]    w_rdata;
    logic signed [DM_W-1:0]   w_dm;
    logic signed [TGT_W-1:0]  w_tgt;
    logic [PLO_W-1:0]         w_plo;
    logic signed [PHI_W-1:0]  w_phi;
    logic [PROD_W-1:0]        w_prod;
    logic [PROD_W-1:0]        w_rnd;
    logic [SUM_W-1:0]         w_sum;
    logic [SUM_W-Q_W:0]       w_top;
    logic                     w_ovf;
    logic [Q_W-1:0]           w_next;

    // settings
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr   <= LEARN_RATE_RESET;
            r_disc <= DISCOUNT_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_LEARN_RATE: r_lr   <= i_cfg_wdata;
                CFG_DISCOUNT:   r_disc <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // addressing
    assign w_base  = ADDR_W'(r_nxt) * ADDR_W'(NUM_ACTIONS);
    assign w_slot  = ADDR_W'(r_prior) * ADDR_W'(NUM_ACTIONS) + ADDR_W'(r_act);
    assign w_raddr = i_cmd.rd_old ? w_slot : w_base + ADDR_W'(i_cmd.rd_idx);
    assign w_we    = i_cmd.clr | i_cmd.fin;
    assign w_waddr = i_cmd.clr ? i_cmd.clr_addr : w_slot;
    assign w_wdata = i_cmd.clr ? '0 : w_next;

    qtu_ram #(
        .WIDTH (Q_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // arithmetic, one register per step
    assign w_dm  = $signed({1'b0, r_disc}) * r_best;
    assign w_tgt = $signed({{(TGT_W-Q_W-CFG_W){r_reward[Q_W-1]}}, r_reward, {CFG_W{1'b0}}})
                 + $signed({{(TGT_W-DM_W){r_dm[DM_W-1]}}, r_dm})
                 - $signed({{(TGT_W-Q_W-CFG_W){r_old[Q_W-1]}}, r_old, {CFG_W{1'b0}}});
    // learn rate times target split into low unsigned and high signed halves
    assign w_plo  = {{LO_W{1'b0}}, r_lr} * {{CFG_W{1'b0}}, r_tgt[LO_W-1:0]};
    assign w_phi  = $signed({1'b0, r_lr}) * $signed(r_tgt[TGT_W-1:LO_W]);
    assign w_prod = {w_phi, {LO_W{1'b0}}} + {{(PROD_W-PLO_W){1'b0}}, r_plo};

    // round half up, floor shift, add old, saturate
    assign w_rnd  = r_prod + ROUND_HALF;
    assign w_sum  = {{(SUM_W-Q_W){r_old[Q_W-1]}}, r_old}
                  + {w_rnd[PROD_W-1], w_rnd[PROD_W-1:SHIFT]};
    assign w_top  = w_sum[SUM_W-1:Q_W-1];
    assign w_ovf  = !((&w_top) || !(|w_top));
    assign w_next = !w_ovf ? w_sum[Q_W-1:0]
                  : (w_sum[SUM_W-1] ? Q_NEG_LIMIT : Q_POS_LIMIT);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_prior  <= ST_W'(32'(i_prior_state) % NUM_STATES);
            r_act    <= ACT_W'(32'(i_taken_action) % NUM_ACTIONS);
            r_nxt    <= ST_W'(32'(i_next_state) % NUM_STATES);
            r_reward <= i_reward_value;
        end
        if (i_cmd.max_first) begin
            r_best <= w_rdata;
        end else if (i_cmd.max_cmp && (w_rdata > r_best)) begin
            r_best <= w_rdata;
        end
        if (i_cmd.old_cap) begin
            r_old <= w_rdata;
        end
        if (i_cmd.mul) begin
            r_dm <= w_dm;
        end
        if (i_cmd.tgt) begin
            r_tgt <= w_tgt;
        end
        if (i_cmd.mlo) begin
            r_plo <= w_plo;
        end
        if (i_cmd.mhi) begin
            r_prod <= w_prod;
        end
        if (i_cmd.fin) begin
            r_upd  <= w_next;
            r_max  <= r_best;
            r_clip <= w_ovf;
        end
    end

    assign o_updated_value = r_upd;
    assign o_next_row_max  = r_max;
    assign o_clipped       = r_clip;

endmodule

`default_nettype wire

[sv/q_table_update_top.sv]
// ----------------------------------------------------------------------------
// q_table_update_top: q-learning table update
// Stream in one transition per item, stream out the updated entry.
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole table of NUM_STATES * NUM_ACTIONS
// entries (2048 with 256 states and 8 actions) to zero, one entry per cycle,
// and takes no item until the sweep is done; configuration writes are taken
// during the sweep. Each item then occupies the block on its own: the single
// read port of the table walks the next-state row one entry per cycle and
// then fetches the old entry, followed by the discount multiply, the target
// sum, a split 16 x 34 bit multiply in a low and a high part, and the
// write-back.
// One item is in flight at a time; a finished result sits in an output
// register so a new item is taken while it waits to be transferred.
`default_nettype none

module q_table_update_top import qtu_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // prior_state[7:0], taken_action[10:8], next_state[18:11],
    // reward_value[34:19], zero pad[39:35]
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // updated_value[15:0], next_row_max[31:16]
    output logic      [M_TDATA_W-1:0] m_axis_tdata,
    // clipped[0]
    output logic                      m_axis_tuser,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata
);

    t_cmd           w_cmd;
    logic [Q_W-1:0] w_upd;
    logic [Q_W-1:0] w_max;

    qtu_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_cmd     (w_cmd)
    );

    qtu_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_prior_state   (s_axis_tdata[7:0]),
        .i_taken_action  (s_axis_tdata[10:8]),
        .i_next_state    (s_axis_tdata[18:11]),
        .i_reward_value  (s_axis_tdata[34:19]),
        .o_updated_value (w_upd),
        .o_next_row_max  (w_max),
        .o_clipped       (m_axis_tuser)
    );

    assign m_axis_tdata = {w_max, w_upd};

endmodule

`default_nettype wire

[sv/qtu_checker.sv]
// ----------------------------------------------------------------------------
// qtu_checker: port-level checks for the q table update
// Watches the top-level ports and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module qtu_checker import qtu_pkg::*; (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 s_axis_tvalid,
    input wire logic                 s_axis_tready,
    input wire logic [M_TDATA_W-1:0] m_axis_tdata,
    input wire logic                 m_axis_tuser,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready
);

    // no result survives reset
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // one item in flight: no second transfer right after one
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken back to back");

    // a saturated result sits on a range limit
    a_clip_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            (m_axis_tdata[15:0] == Q_POS_LIMIT) || (m_axis_tdata[15:0] == Q_NEG_LIMIT))
        else $error("clipped flag without limit value");

    // a result never appears in the cycle after an input transfer
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
        else $error("result too soon after input");

endmodule

bind q_table_update_top qtu_checker u_checker (.*);

`default_nettype wire

[tb/sv/q_table_update_top_test.sv]
// ----------------------------------------------------------------------------
// q_table_update_top_test: self-checking bench for the q table update block
// Streams state transitions into the block under random idling on both
// sides, predicts every updated entry, row maximum and clip flag from a
// private copy of the table and the learning registers, and compares each
// output transfer with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module q_table_update_top_test;
    import qtu_pkg::*;

    localparam int IDLE_LIMIT      = 6000;
    localparam int DRAIN_CYCLES    = NUM_ACTIONS + 8;
    localparam int HOLD_CYCLES     = 400;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int NUM_PHASES      = 8;
    localparam int MAX_REPORTS     = 10;

    // prior_state lowest, reward_value highest, same order as s_axis_tdata
    typedef struct packed {
        logic signed [Q_W-1:0]      reward;
        logic        [NEXT_W-1:0]   next_st;
        logic        [ACTION_W-1:0] action;
        logic        [PRIOR_W-1:0]  prior;
    } t_transition;

    typedef struct packed {
        logic signed [Q_W-1:0] value;
        logic signed [Q_W-1:0] row_max;
        logic                  clipped;
    } t_q_update;

    class t_q_value_scoreboard;
        logic signed [Q_W-1:0] q_vals [DEPTH];
        logic [CFG_W-1:0]      rate;
        logic [CFG_W-1:0]      discount;
        t_q_update             expected_updates [$];
        int                    mismatches;

        function new();
            foreach (q_vals[i]) q_vals[i] = '0;
            rate       = LEARN_RATE_RESET;
            discount   = DISCOUNT_RESET;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_LEARN_RATE: rate = val;
                CFG_DISCOUNT:   discount = val;
                default: ;
            endcase
        endfunction

        // one bellman step on the private table
        function void note_transition(t_transition tr);
            int unsigned row;
            int unsigned slot;
            longint      best;
            longint      old;
            longint      target;
            longint      prod;
            longint      sum;
            t_q_update   upd;
            row  = (int'(tr.next_st) % NUM_STATES) * NUM_ACTIONS;
            slot = (int'(tr.prior) % NUM_STATES) * NUM_ACTIONS
                 + (int'(tr.action) % NUM_ACTIONS);
            best = q_vals[row];
            for (int k = 1; k < NUM_ACTIONS; k++) begin
                if (q_vals[row + k] > best) best = q_vals[row + k];
            end
            // the row maximum is read before the entry is written
            old    = q_vals[slot];
            target = longint'($signed(tr.reward)) * 65536
                   + longint'(discount) * best - old * 65536;
            prod   = longint'(rate) * target;
            sum    = old + ((prod + 64'sd2147483648) >>> 32);
            upd.clipped = 1'b0;
            if (sum > 32767) begin
                sum = 32767;
                upd.clipped = 1'b1;
            end else if (sum < -32768) begin
                sum = -32768;
                upd.clipped = 1'b1;
            end
            q_vals[slot]  = sum[Q_W-1:0];
            upd.value     = sum[Q_W-1:0];
            upd.row_max   = best[Q_W-1:0];
            expected_updates.push_back(upd);
        endfunction

        function int outstanding();
            return expected_updates.size();
        endfunction

        function void check_update(t_q_update got);
            t_q_update want;
            if (expected_updates.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: value %0d max %0d clipped %0b",
                             got.value, got.row_max, got.clipped);
                return;
            end
            want = expected_updates.pop_front();
            if (want != got) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("mismatch: expected value %0d max %0d clipped %0b",
                             want.value, want.row_max, want.clipped);
                    $display("          got value %0d max %0d clipped %0b",
                             got.value, got.row_max, got.clipped);
                end
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    // prior_state[7:0], taken_action[10:8], next_state[18:11],
    // reward_value[34:19], zero pad[39:35]
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // updated_value[15:0], next_row_max[31:16]
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    // clipped[0]
    logic                  m_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_W-1:0]      i_cfg_wdata = '0;

    t_q_value_scoreboard   scoreboard = new();
    bit                    tx_idle = 1'b1;
    bit                    rx_idle = 1'b1;
    bit                    rx_hold_request = 1'b0;

    q_table_update_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_transition make_transition(int prior, int action, int next_st,
                                                    int reward);
        t_transition tr;
        tr.prior   = prior[PRIOR_W-1:0];
        tr.action  = action[ACTION_W-1:0];
        tr.next_st = next_st[NEXT_W-1:0];
        tr.reward  = reward[Q_W-1:0];
        return tr;
    endfunction

    // most transitions stay within a few rows so the table fills up
    function automatic t_transition random_transition();
        int prior;
        int next_st;
        int reward;
        int sel;
        prior = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 7) : $urandom_range(0, 255);
        sel = $urandom_range(0, 99);
        if (sel < 15) next_st = prior;
        else if (sel < 70) next_st = $urandom_range(0, 7);
        else next_st = $urandom_range(0, 255);
        sel = $urandom_range(0, 99);
        if (sel < 15) begin
            case ($urandom_range(0, 2))
                0: reward = 32767;
                1: reward = -32768;
                default: reward = 0;
            endcase
        end else if (sel < 60) begin
            reward = $urandom_range(0, 8191) - 4096;
        end else begin
            reward = $urandom;
        end
        return make_transition(prior, $urandom_range(0, 7), next_st, reward);
    endfunction

    task automatic send_transition(t_transition tr);
        int gap;
        s_axis_tdata  <= S_TDATA_W'(tr);
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        scoreboard.note_transition(tr);
        gap = 0;
        if (tx_idle && $urandom_range(0, 1) == 1) gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop offering and wait until every predicted update has come back
    task automatic drain_updates();
        s_axis_tvalid <= 1'b0;
        while (scoreboard.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_learning_regs(logic [CFG_W-1:0] rate, logic [CFG_W-1:0] discount);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_LEARN_RATE;
        i_cfg_wdata <= rate;
        @(posedge i_clk);
        i_cfg_index <= CFG_DISCOUNT;
        i_cfg_wdata <= discount;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        scoreboard.write_reg(CFG_LEARN_RATE, rate);
        scoreboard.write_reg(CFG_DISCOUNT, discount);
    endtask

    // result side: random stalls plus an optional long hold-off
    initial begin
        int rx_wait;
        rx_wait = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                scoreboard.check_update(t_q_update'({m_axis_tdata[15:0],
                                                     m_axis_tdata[31:16],
                                                     m_axis_tuser}));
            if (rx_hold_request) begin
                rx_wait = HOLD_CYCLES;
                rx_hold_request = 1'b0;
            end
            if (rx_wait > 0) begin
                m_axis_tready <= 1'b0;
                rx_wait--;
            end else begin
                m_axis_tready <= 1'b1;
                if (rx_idle && $urandom_range(0, 3) == 0) rx_wait = pick_gap();
            end
        end
    end

    // ends the run when no transfer happens for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        logic [CFG_W-1:0] rate;
        logic [CFG_W-1:0] discount;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corners of every field at the reset learning registers
        send_transition(make_transition(0, 0, 0, 32767));
        send_transition(make_transition(255, 7, 255, -32768));
        send_transition(make_transition(0, 7, 0, 0));
        send_transition(make_transition(255, 0, 0, 1));
        send_transition(make_transition(170, 5, 85, -1));
        send_transition(make_transition(85, 2, 170, 16'h5555));
        drain_updates();

        // full rate and discount: positive clipping, then a row driven
        // all negative, updated from itself, for negative clipping
        write_learning_regs(16'hffff, 16'hffff);
        send_transition(make_transition(1, 3, 1, 32767));
        send_transition(make_transition(2, 0, 1, 32767));
        send_transition(make_transition(1, 4, 1, 32767));
        for (int a = 0; a < NUM_ACTIONS; a++)
            send_transition(make_transition(6, a, 6, -32768));
        send_transition(make_transition(6, 0, 6, -32768));
        drain_updates();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin rate = LEARN_RATE_RESET; discount = DISCOUNT_RESET; end
                1: begin rate = 16'hffff; discount = 16'hffff; end
                2: begin rate = 16'h0000; discount = 16'h0000; end
                3: begin rate = 16'hffff; discount = 16'h0000; end
                4: begin rate = 16'h0000; discount = 16'hffff; end
                5: begin rate = 16'h8000; discount = 16'hc000; end
                default: begin rate = CFG_W'($urandom); discount = CFG_W'($urandom); end
            endcase
            write_learning_regs(rate, discount);
            tx_idle = (phase != 1) && (phase != 5);
            rx_idle = (phase != 5);
            // back-pressure long enough to fill the block and stall its input
            if (phase == 1) rx_hold_request = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (phase == 3 && n == ITEMS_PER_PHASE / 2) drain_updates();
                send_transition(random_transition());
            end
            drain_updates();
        end

        if (scoreboard.mismatches == 0 && scoreboard.outstanding() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
